FILE: rtl/sha256_hash_stream_assert.svh
// Assertion macros for the SHA-256 stream hasher.
// Used by modules that check their own control logic.
`ifndef SHA256_HASH_STREAM_ASSERT_SVH
`define SHA256_HASH_STREAM_ASSERT_SVH
// implication checked on every clock, disabled in reset
`define SHS_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define SHS_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

FILE: rtl/shs_pkg.sv
// Package for the SHA-256 stream hasher: constants, round table, round functions.
// No dependencies.
`timescale 1ns / 1ps
package shs_pkg;
    localparam int BLOCK_BYTES = 64;
    localparam int LEN_OFFSET  = 56;
    localparam int ROUNDS      = 64;

    localparam logic [31:0] IV_256 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam logic [31:0] IV_224 [8] = '{
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};
    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    typedef logic [31:0] word_t;

    // compressor control from the sequencer
    typedef struct packed {
        logic start;
    } cmp_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cmp_sts_t;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t sig0(input word_t x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t sig1(input word_t x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction
endpackage

FILE: rtl/shs_compress.sv
// SHA-256 compression: block words in a 16-entry schedule memory, one round a cycle.
// Depends on shs_pkg. Reads the block buffer memory of the top level by word.
`timescale 1ns / 1ps
module shs_compress
    import shs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmp_ctl_t    ctl,
    input  word_t       chain_in [8],
    output logic [3:0]  blk_addr,
    input  word_t       blk_data,
    output word_t       work_out [8],
    output cmp_sts_t    sts
);
    `include "sha256_hash_stream_assert.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    word_t      v_reg [8];
    word_t      sched [16];  // schedule kept as shift window of 16 words
    word_t      w, t1, t2, s1e, s0a, ch, maj;

    // load phase: 16 word reads; the block memory read is registered
    assign blk_addr = cnt_reg[3:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = S_LOAD;
                    cnt_next = '0;
                end
            end
            S_LOAD:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd16)
                begin
                    state_next = S_RUN;
                    cnt_next = '0;
                end
            end
            S_RUN:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(ROUNDS - 1))
                    state_next = S_DONE;
            end
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    // window: sched[0] is w[r], sched[1] w[r+1], sched[9] w[r+9], sched[14] w[r+14]
    always_comb
    begin
        w = sched[0];
        s1e = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + s1e + ch + ROUND_K[cnt_reg[5:0]] + w;
        s0a = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = s0a + maj;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD && cnt_reg != 7'd0)
        begin
            for (int i = 0; i < 15; i++)
                sched[i] <= sched[i+1];
            sched[15] <= blk_data;
        end
        if (state_reg == S_LOAD && cnt_reg == 7'd16)
            for (int i = 0; i < 8; i++)
                v_reg[i] <= chain_in[i];
        if (state_reg == S_RUN)
        begin
            for (int i = 0; i < 15; i++)
                sched[i] <= sched[i+1];
            sched[15] <= sig1(sched[14]) + sched[9] + sig0(sched[1]) + sched[0];
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign work_out = v_reg;
    assign sts.busy = (state_reg != S_IDLE);
    assign sts.done = (state_reg == S_DONE);

    `SHS_ASSERT_IMP(a_start_idle, clk, rst_n, ctl.start, state_reg == S_IDLE, "start while busy")
    `SHS_ASSERT_NEXT(a_run_done, clk, rst_n, state_reg == S_RUN && cnt_reg == 7'd63, sts.done, "no done after last round")
    `SHS_ASSERT_IMP(a_run_cnt, clk, rst_n, state_reg == S_RUN, cnt_reg < 7'd64, "round count out of range")
endmodule

FILE: rtl/sha256_hash_stream.sv
// SHA-256 / SHA-224 stream hasher, one message byte per item. Each accepted byte is
// written into a 64-byte block memory; the 64th byte of a block stalls the input
// while the compressor loads the schedule from the memory and runs 64 rounds, and
// the chain is updated. End of message adds one or two padding blocks (a fill sweep
// over the block memory plus a compression each) and eight or seven output items.
// No byte is taken while a block is compressed or padded or the digest is output.
`timescale 1ns / 1ps
module sha256_hash_stream
    import shs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  msg_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    `include "sha256_hash_stream_assert.svh"

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_CMP  = 3'd1;  // full data block compressing
    localparam logic [2:0] M_PAD  = 3'd2;  // padding sweep over block memory
    localparam logic [2:0] M_PCMP = 3'd3;  // padding block compressing
    localparam logic [2:0] M_OUT  = 3'd4;

    logic [2:0]  st_reg, st_next;
    logic        d224_reg;
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [63:0] len_reg;
    logic        two_reg;      // a padding block follows the current block
    logic [6:0]  sw_reg;       // sweep position, 64 = done
    logic [2:0]  oi_reg;
    word_t       chain_reg [8];

    // block memory, four byte lanes so the compressor reads a word per cycle
    logic [7:0]  mem0 [16];
    logic [7:0]  mem1 [16];
    logic [7:0]  mem2 [16];
    logic [7:0]  mem3 [16];
    logic [3:0]  rd_addr;
    word_t       rd_data_reg;
    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [7:0]  wr_data;

    cmp_ctl_t    cctl;
    cmp_sts_t    csts;
    word_t       work [8];

    logic in_acc, out_acc;
    logic [7:0] pad_byte;
    logic [5:0] sw;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;
    assign in_stall = (st_reg != M_IDLE);
    assign sw = sw_reg[5:0];

    // padding byte at sweep position sw (fill is where 0x80 goes in the first block)
    always_comb
    begin
        pad_byte = 8'h00;
        if (!two_reg && sw >= 6'(LEN_OFFSET))
            pad_byte = len_reg[6'(63 - 8*(sw - 6'(LEN_OFFSET))) -: 8];
        else if (sw == fill_reg && sw_reg[6] == 1'b0 && len_reg[0] == 1'b0 && !bits_reg[0])
            pad_byte = 8'h80;
    end

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = fill_reg;
        wr_data = msg_byte;
        if (st_reg == M_IDLE && in_acc && byte_present)
            wr_en = 1'b1;
        else if (st_reg == M_PAD && sw_reg < 7'd64 && (sw >= fill_reg || two_reg == 1'b0))
        begin
            wr_en = (sw >= fill_reg) || (sw_reg >= 7'(LEN_OFFSET)) || (bits_reg[0]);
            wr_addr = sw;
            wr_data = pad_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            case (wr_addr[1:0])
                2'd0:    mem0[wr_addr[5:2]] <= wr_data;
                2'd1:    mem1[wr_addr[5:2]] <= wr_data;
                2'd2:    mem2[wr_addr[5:2]] <= wr_data;
                default: mem3[wr_addr[5:2]] <= wr_data;
            endcase
        rd_data_reg <= {mem0[rd_addr], mem1[rd_addr], mem2[rd_addr], mem3[rd_addr]};
    end

    shs_compress u_cmp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cctl),
        .chain_in (chain_reg),
        .blk_addr (rd_addr),
        .blk_data (rd_data_reg),
        .work_out (work),
        .sts      (csts)
    );

    always_comb
    begin
        st_next = st_reg;
        cctl.start = 1'b0;
        case (st_reg)
            M_IDLE:
            begin
                if (in_acc)
                begin
                    if (byte_present && fill_reg == 6'd63)
                    begin
                        st_next = M_CMP;
                        cctl.start = 1'b1;
                    end
                    else if (end_of_message)
                        st_next = M_PAD;
                end
            end
            M_CMP:
            begin
                if (csts.done)
                    st_next = two_reg ? M_PAD : M_IDLE;
            end
            M_PAD:
            begin
                if (sw_reg == 7'd64)
                begin
                    st_next = M_PCMP;
                    cctl.start = 1'b1;
                end
            end
            M_PCMP:
            begin
                if (csts.done)
                    st_next = two_reg ? M_PAD : M_OUT;
            end
            M_OUT:
            begin
                if (out_acc && last_word)
                    st_next = M_IDLE;
            end
            default: st_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= M_IDLE;
            d224_reg <= 1'b0;
            fill_reg <= '0;
            bits_reg <= '0;
            len_reg <= '0;
            two_reg <= 1'b0;
            sw_reg <= '0;
            oi_reg <= '0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= IV_256[i];
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_we)
            begin
                d224_reg <= cfg_wdata;
                fill_reg <= '0;
                bits_reg <= '0;
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= cfg_wdata ? IV_224[i] : IV_256[i];
            end
            else
            begin
                case (st_reg)
                    M_IDLE:
                    begin
                        if (in_acc)
                        begin
                            logic [5:0] f;
                            f = fill_reg;
                            if (byte_present)
                            begin
                                f = fill_reg + 6'd1;
                                fill_reg <= f;
                                if (fill_reg == 6'd63)
                                    bits_reg <= bits_reg + 64'd512;
                            end
                            len_reg <= bits_reg + (byte_present && fill_reg == 6'd63
                                       ? 64'd512 : {55'd0, f, 3'd0});
                            sw_reg <= '0;
                            oi_reg <= '0;
                            // two pad blocks, or end pending after a full block
                            if (end_of_message && !(byte_present && fill_reg == 6'd63))
                                two_reg <= (f >= 6'(LEN_OFFSET));
                            else
                                two_reg <= end_of_message && byte_present
                                           && fill_reg == 6'd63;
                        end
                    end
                    M_CMP:
                    begin
                        if (csts.done)
                        begin
                            for (int i = 0; i < 8; i++)
                                chain_reg[i] <= chain_reg[i] + work[i];
                            // end of message arrived with the 64th byte: pad an empty tail
                            if (two_reg)
                                two_reg <= 1'b0;
                        end
                    end
                    M_PAD:
                    begin
                        if (sw_reg != 7'd64)
                            sw_reg <= sw_reg + 7'd1;
                    end
                    M_PCMP:
                    begin
                        if (csts.done)
                        begin
                            for (int i = 0; i < 8; i++)
                                chain_reg[i] <= chain_reg[i] + work[i];
                            sw_reg <= '0;
                            if (two_reg)
                            begin
                                two_reg <= 1'b0;
                                fill_reg <= '0;
                                bits_reg[0] <= 1'b1;  // marks 0x80 already placed
                            end
                        end
                    end
                    M_OUT:
                    begin
                        if (out_acc)
                        begin
                            oi_reg <= oi_reg + 3'd1;
                            if (last_word)
                            begin
                                fill_reg <= '0;
                                bits_reg <= '0;
                                for (int i = 0; i < 8; i++)
                                    chain_reg[i] <= d224_reg ? IV_224[i] : IV_256[i];
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign out_valid   = (st_reg == M_OUT);
    assign digest_word = chain_reg[oi_reg];
    assign word_index  = oi_reg;
    assign last_word   = d224_reg ? (oi_reg == 3'd6) : (oi_reg == 3'd7);

    `SHS_ASSERT_IMP(a_no_in_busy, clk, rst_n, csts.busy, in_stall, "input taken while compressing")
    `SHS_ASSERT_IMP(a_out_only, clk, rst_n, out_valid, !csts.busy, "output during compression")
    `SHS_ASSERT_NEXT(a_out_end, clk, rst_n, out_acc && last_word, st_reg == M_IDLE, "output not closed")
endmodule

FILE: tb/tb_sha256_hash_stream.sv
// Self-checking testbench for sha256_hash_stream: byte stream in, digest words out.
// Predicts SHA-256 / SHA-224 digests with its own compression model.
// Depends on shs_pkg (initial values, round constants) and the RTL top level.
`timescale 1ns / 1ps
module tb_sha256_hash_stream;
    import shs_pkg::*;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
    } byte_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  msg_byte = '0;
    logic        byte_present = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    sha256_hash_stream DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .msg_byte(msg_byte),
        .byte_present(byte_present), .end_of_message(end_of_message),
        .out_valid(out_valid), .out_stall(out_stall), .digest_word(digest_word),
        .word_index(word_index), .last_word(last_word)
    );

    always #4 clk = ~clk;

    // predictor state
    logic        sel_224;
    logic [7:0]  blk [64];
    int          fill;
    logic [63:0] bit_count;
    logic [31:0] chain [8];

    byte_item_t   pending_bytes[$];
    digest_item_t expected_words[$];
    int  mismatches = 0;
    int  words_seen = 0;
    int  digests_seen = 0;
    longint cycles = 0;
    bit  hold_receiver = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    int  stall_left = 0;

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic restart_hash();
        for (int j = 0; j < 8; j++)
            chain[j] = sel_224 ? IV_224[j] : IV_256[j];
        fill = 0;
        bit_count = '0;
    endtask

    task automatic compress();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wr, t1, t2, a, b;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int j = 0; j < 8; j++)
            v[j] = chain[j];
        for (int r = 0; r < 64; r++)
        begin
            if (r < 16)
                wr = w[r];
            else
            begin
                a = w[(r + 1) & 15];
                b = w[(r + 14) & 15];
                wr = (ror(b, 17) ^ ror(b, 19) ^ (b >> 10)) + w[(r + 9) & 15]
                     + (ror(a, 7) ^ ror(a, 18) ^ (a >> 3)) + w[r & 15];
                w[r & 15] = wr;
            end
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + wr;
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++)
            chain[j] += v[j];
    endtask

    task automatic predict_digest(byte_item_t it);
        logic [63:0] len;
        int i, count;
        digest_item_t d;
        if (it.byte_present)
        begin
            blk[fill] = it.msg_byte;
            fill++;
            if (fill == 64)
            begin
                compress();
                bit_count += 64'd512;
                fill = 0;
            end
        end
        if (!it.end_of_message)
            return;
        len = bit_count + 64'(fill) * 8;
        i = fill;
        blk[i] = 8'h80;
        i = i + 1;
        if (i > 56)
        begin
            for (int k = i; k < 64; k++)
                blk[k] = 8'h00;
            compress();
            i = 0;
        end
        for (int k = i; k < 56; k++)
            blk[k] = 8'h00;
        for (int k = 0; k < 8; k++)
            blk[56 + k] = len[63 - 8*k -: 8];
        compress();
        count = sel_224 ? 7 : 8;
        for (int k = 0; k < count; k++)
        begin
            d.digest_word = chain[k];
            d.word_index = 3'(k);
            d.last_word = (k == count - 1);
            expected_words.push_back(d);
        end
        restart_hash();
    endtask

    // driver
    int in_gap = 0;
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            predict_digest({msg_byte, byte_present, end_of_message});
            void'(pending_bytes.pop_front());
        end
        if (in_valid && in_stall)
            ;
        else if (in_gap > 0)
        begin
            in_gap <= in_gap - 1;
            in_valid <= 1'b0;
        end
        else if ((in_valid && !in_stall ? pending_bytes.size() > 0 :
                  pending_bytes.size() > 0))
        begin
            in_valid <= 1'b1;
            {msg_byte, byte_present, end_of_message} <= pending_bytes[0];
            if ($urandom_range(0, 9) < 3)
                in_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                      : $urandom_range(1, 3);
        end
        else
            in_valid <= 1'b0;
    end

    // receiver stall: one long counted hold on request, otherwise random gaps
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_receiver && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_left <= 1500;
            hold_done <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 9) < 3)
        begin
            out_stall <= 1'b1;
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                       : $urandom_range(0, 2);
        end
        else
            out_stall <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (out_valid && !out_stall)
        begin
            words_seen <= words_seen + 1;
            if (last_word)
                digests_seen <= digests_seen + 1;
            if (expected_words.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("ERROR: unexpected digest word %h index %0d",
                             digest_word, word_index);
            end
            else
            begin
                digest_item_t e;
                e = expected_words.pop_front();
                if (e.digest_word !== digest_word || e.word_index !== word_index
                    || e.last_word !== last_word)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("ERROR: expected %h/%0d/%b got %h/%0d/%b",
                                 e.digest_word, e.word_index, e.last_word,
                                 digest_word, word_index, last_word);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > 2000000)
        begin
            $display("ERROR: timeout");
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic byte_item_t mk(logic [7:0] b, logic p, logic e);
        byte_item_t it;
        it.msg_byte = b;
        it.byte_present = p;
        it.end_of_message = e;
        return it;
    endfunction

    task automatic push_message(int len, bit rnd_bytes);
        for (int k = 0; k < len; k++)
            pending_bytes.push_back(mk(rnd_bytes ? 8'($urandom) : 8'(k), 1'b1,
                                       k == len - 1));
    endtask

    task automatic drain();
        while (pending_bytes.size() > 0 || in_valid || expected_words.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_select(logic s);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_we <= 1'b0;
        sel_224 = s;
        restart_hash();
    endtask

    initial
    begin
        int len;
        sel_224 = 1'b0;
        restart_hash();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty message, extremes, empty items, padding boundaries
        pending_bytes.push_back(mk(8'h00, 1'b0, 1'b1));
        pending_bytes.push_back(mk(8'hff, 1'b1, 1'b1));
        pending_bytes.push_back(mk(8'h00, 1'b1, 1'b0));
        pending_bytes.push_back(mk(8'ha5, 1'b0, 1'b0));
        pending_bytes.push_back(mk(8'h5a, 1'b0, 1'b1));
        drain();
        push_message(55, 1'b0);
        push_message(56, 1'b1);
        drain();
        write_select(1'b1);
        pending_bytes.push_back(mk(8'h00, 1'b0, 1'b1));
        push_message(64, 1'b1);
        drain();

        // long receiver hold while bytes keep coming
        hold_receiver = 1'b1;
        push_message(3, 1'b1);
        push_message(2, 1'b1);
        push_message(4, 1'b1);
        drain();

        // partial message discarded by a register write
        push_message(5, 1'b1);
        void'(pending_bytes.pop_back());
        pending_bytes.push_back(mk(8'h33, 1'b1, 1'b0));
        drain();
        write_select(1'b0);

        // random short messages in both modes
        for (int m = 0; m < 4; m++)
        begin
            if (m == 2)
            begin
                drain();
                write_select(1'b1);
            end
            len = $urandom_range(0, 3);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                    pending_bytes.push_back(mk(8'($urandom), 1'b0, 1'b0));
                pending_bytes.push_back(mk(8'($urandom), 1'b1, 1'b0));
            end
            pending_bytes.push_back(mk(8'($urandom), 1'($urandom), 1'b1));
        end
        drain();

        $display("Run covered %0d digests (%0d words) in SHA-256 and SHA-224 modes,",
                 digests_seen, words_seen);
        $display("including padding boundaries, empty messages and a long output hold.");
        if (mismatches == 0 && expected_words.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
